// ----- sv/qclt_pkg.sv -----
// Shared types and constants for the quoted command-line tokeniser.
// No dependencies; imported by every module of the block.
package qclt_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_END_TOKEN = 2'd1,
    KIND_LINE_DONE = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [1:0] mode;
    logic       just_closed;
    logic       token_open;
  } tok_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] token_char;
  } result_t;

  // all results caused by one input word, in emission order from index 0
  typedef struct packed {
    logic [1:0]               count;
    result_t [MAX_RES-1:0]    res;
  } res_list_t;

endpackage

// ----- sv/qclt_step.sv -----
// Next-state and result-list logic for one input word of the tokeniser.
// Depends on qclt_pkg.
module qclt_step (
  input  qclt_pkg::tok_state_t cur,
  input  logic [7:0]           ch,
  input  logic                 has_char,
  input  logic                 line_end,
  output qclt_pkg::tok_state_t nxt,
  output qclt_pkg::res_list_t  list
);
  import qclt_pkg::*;

  logic       quoted;
  logic [7:0] closer;

  always_comb begin
    nxt        = cur;
    list       = '0;
    quoted     = (cur.mode == MODE_SINGLE) || (cur.mode == MODE_DOUBLE);
    closer     = (cur.mode == MODE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

    if (has_char) begin
      if (quoted) begin
        if (ch == closer) begin
          nxt.just_closed = 1'b1;
          nxt.mode        = MODE_NORMAL;
        end else begin
          list.res[list.count] = '{kind: KIND_CHAR, token_char: ch};
          list.count           = list.count + 2'd1;
          nxt.token_open       = 1'b1;
        end
      end else begin
        if (ch == CH_SQUOTE) begin
          nxt.mode = MODE_SINGLE;
        end else if (ch == CH_DQUOTE) begin
          nxt.mode = MODE_DOUBLE;
        end else if (ch == CH_SPACE) begin
          if (cur.just_closed || cur.token_open) begin
            list.res[list.count] = '{kind: KIND_END_TOKEN, token_char: 8'h00};
            list.count           = list.count + 2'd1;
            nxt.token_open       = 1'b0;
          end
        end else begin
          list.res[list.count] = '{kind: KIND_CHAR, token_char: ch};
          list.count           = list.count + 2'd1;
          nxt.token_open       = 1'b1;
        end
        nxt.just_closed = 1'b0;
      end
    end

    if (line_end) begin
      if (nxt.just_closed || nxt.token_open) begin
        list.res[list.count] = '{kind: KIND_END_TOKEN, token_char: 8'h00};
        list.count           = list.count + 2'd1;
      end
      // unknown mode code counts as normal
      if ((nxt.mode == MODE_SINGLE) || (nxt.mode == MODE_DOUBLE)) begin
        list.res[list.count] = '{kind: KIND_ERROR, token_char: 8'h00};
      end else begin
        list.res[list.count] = '{kind: KIND_LINE_DONE, token_char: 8'h00};
      end
      list.count = list.count + 2'd1;
      nxt        = '{mode: MODE_NORMAL, just_closed: 1'b0, token_open: 1'b0};
    end
  end

endmodule

// ----- sv/qclt_outbuf.sv -----
// Result register: holds the up to three results of one input word and
// hands them out one per cycle while the receiver takes them, head first. Depends on qclt_pkg.
module qclt_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  qclt_pkg::res_list_t load_list,
  input  logic                pop,
  output qclt_pkg::result_t   head,
  output logic [1:0]          count
);
  import qclt_pkg::*;

  result_t [MAX_RES-1:0] slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= load_list.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_list.res;
    end else if (pop) begin
      slots <= {result_t'('0), slots[MAX_RES-1:1]};
    end
  end

  assign head = slots[0];

endmodule

// ----- sv/quoted_command_line_tokenizer_top.sv -----
// Top level of the quoted command-line tokeniser: state registers, step
// logic and result register. Depends on qclt_pkg, qclt_step, qclt_outbuf.
//
//  channel | dir | tdata                 | tuser    | tlast
//  s_axis  | in  | [7:0] ch              | has_char | line_end
//  m_axis  | out | [1:0] kind, [9:2] chr | -        | run_last
//
// A word is taken every cycle while it causes at most one result and the
// receiver is ready; a word that causes two or three results holds the input
// while the result register drains (one result leaves per cycle when taken).
// The input is taken when the result register is empty or hands out its
// final result in the same cycle. rst is synchronous and returns the quote
// state and the result register to empty.
module quoted_command_line_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] kind, [9:2] token_char, rest zero
  output logic        m_axis_tlast    // run_last
);
  import qclt_pkg::*;

  tok_state_t state;
  tok_state_t state_next;
  res_list_t  list;
  result_t    head;
  logic [1:0] count;
  logic       in_fire;
  logic       out_fire;

  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count == 2'd0) || ((count == 2'd1) && m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  qclt_step u_step (
    .cur      (state),
    .ch       (s_axis_tdata),
    .has_char (s_axis_tuser),
    .line_end (s_axis_tlast),
    .nxt      (state_next),
    .list     (list)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: MODE_NORMAL, just_closed: 1'b0, token_open: 1'b0};
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  qclt_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (in_fire),
    .load_list (list),
    .pop       (out_fire),
    .head      (head),
    .count     (count)
  );

  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tlast  = (count == 2'd1);
  assign m_axis_tdata  = {6'd0, head.token_char, head.kind};

endmodule

// ----- bench/tokenizer_checker.sv -----
// Checker for the quoted command-line tokeniser: watches both stream channels,
// predicts the result words of every accepted input word and compares them.
// Depends on qclt_pkg; instantiated beside the block by the bench top.
module tokenizer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [1:0] kind, [9:2] token_char
  input  logic        m_axis_tlast,
  output int          failures,
  output int          pending
);
  import qclt_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] chr;
    logic       last;
  } tok_word_t;

  tok_word_t  awaited_words[$];

  // own copy of the tokeniser state
  logic [1:0] quote_st;
  logic       closed_q;
  logic       arg_open;

  task automatic tokenize_word(input logic [7:0] c, input logic hc, input logic le);
    kind_t      ks [3];
    logic [7:0] cs [3];
    tok_word_t  w;
    int         n;
    n = 0;
    if (hc) begin
      if (quote_st == MODE_SINGLE || quote_st == MODE_DOUBLE) begin
        if (c == ((quote_st == MODE_SINGLE) ? CH_SQUOTE : CH_DQUOTE)) begin
          closed_q = 1'b1;
          quote_st = MODE_NORMAL;
        end else begin
          ks[n] = KIND_CHAR;
          cs[n] = c;
          n++;
          arg_open = 1'b1;
        end
      end else begin
        // mode 3 is handled as normal
        if (c == CH_SQUOTE) begin
          quote_st = MODE_SINGLE;
        end else if (c == CH_DQUOTE) begin
          quote_st = MODE_DOUBLE;
        end else if (c == CH_SPACE) begin
          if (closed_q || arg_open) begin
            ks[n] = KIND_END_TOKEN;
            cs[n] = 8'h00;
            n++;
            arg_open = 1'b0;
          end
        end else begin
          ks[n] = KIND_CHAR;
          cs[n] = c;
          n++;
          arg_open = 1'b1;
        end
        closed_q = 1'b0;
      end
    end
    if (le) begin
      if (closed_q || arg_open) begin
        ks[n] = KIND_END_TOKEN;
        cs[n] = 8'h00;
        n++;
      end
      ks[n] = (quote_st == MODE_SINGLE || quote_st == MODE_DOUBLE) ? KIND_ERROR
                                                                   : KIND_LINE_DONE;
      cs[n] = 8'h00;
      n++;
      quote_st = MODE_NORMAL;
      closed_q = 1'b0;
      arg_open = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      w.kind = ks[i];
      w.chr  = cs[i];
      w.last = (i == n - 1);
      awaited_words = {awaited_words, w};
    end
  endtask

  task automatic flag(input string what, input tok_word_t want, input tok_word_t got);
    failures++;
    if (failures <= 10)
      $display("%0t %s: expected kind %0d char %02h last %0b, got kind %0d char %02h last %0b",
               $time, what, want.kind, want.chr, want.last, got.kind, got.chr, got.last);
  endtask

  always @(posedge clk) begin
    tok_word_t got;
    tok_word_t want;
    if (rst) begin
      quote_st = MODE_NORMAL;
      closed_q = 1'b0;
      arg_open = 1'b0;
      failures = 0;
    end else begin
      // results are registered, so a word taken at this edge cannot leave yet
      if (s_axis_tvalid && s_axis_tready)
        tokenize_word(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_t'(m_axis_tdata[1:0]);
        got.chr  = m_axis_tdata[9:2];
        got.last = m_axis_tlast;
        if (awaited_words.size() == 0) begin
          want = '0;
          flag("result with none awaited", want, got);
        end else begin
          want = awaited_words.pop_front();
          if (got.kind !== want.kind || got.chr !== want.chr || got.last !== want.last)
            flag("result mismatch", want, got);
        end
      end
    end
    pending = awaited_words.size();
  end

endmodule

// ----- bench/tb_quoted_command_line_tokenizer_top.sv -----
// Bench top for the quoted command-line tokeniser: clock, reset, stimulus
// and verdict. Depends on qclt_pkg, quoted_command_line_tokenizer_top and
// tokenizer_checker.
module tb_quoted_command_line_tokenizer_top;
  import qclt_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] ch
  logic        s_axis_tuser = 1'b0;   // [0] has_char
  logic        s_axis_tlast = 1'b0;   // line_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [1:0] kind, [9:2] token_char
  logic        m_axis_tlast;          // run_last

  int          failures;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_off = 1'b0;
  int          words_sent = 0;

  always #6 clk = ~clk;

  quoted_command_line_tokenizer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  tokenizer_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .failures      (failures),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input logic [7:0] c, input logic hc, input logic le);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= hc;
    s_axis_tlast  <= le;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (hc || le) words_sent++;
  endtask

  // ordinary argument byte: never a space or a quote
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_SPACE || b == CH_SQUOTE || b == CH_DQUOTE)
      b = 8'($urandom_range(8'h41, 8'h7E));
    return b;
  endfunction

  task automatic send_line(input bit noisy);
    logic [7:0] text[$];
    logic [7:0] q;
    logic [7:0] b;
    int         pieces;
    bit         end_on_char;
    if (noisy) begin
      repeat ($urandom_range(10)) begin
        case ($urandom_range(9))
          0, 1:    text = {text, CH_SPACE};
          2:       text = {text, CH_SQUOTE};
          3:       text = {text, CH_DQUOTE};
          default: text = {text, 8'($urandom_range(255))};
        endcase
      end
    end else begin
      pieces = $urandom_range(4);
      repeat (pieces) begin
        repeat ($urandom_range(2)) text = {text, CH_SPACE};
        if ($urandom_range(1) == 0) begin
          repeat ($urandom_range(1, 4)) text = {text, plain_byte()};
        end else begin
          q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
          text = {text, q};
          repeat ($urandom_range(4)) begin
            b = 8'($urandom_range(255));
            text = {text, ((b == q) ? CH_SPACE : b)};
          end
          text = {text, q};
        end
      end
      // a stray quote leaves the line unbalanced
      if ($urandom_range(9) == 0) begin
        text = {text, ($urandom_range(1) ? CH_SQUOTE : CH_DQUOTE)};
        repeat ($urandom_range(2)) text = {text, plain_byte()};
      end
      repeat ($urandom_range(1)) text = {text, CH_SPACE};
    end
    end_on_char = (text.size() != 0) && ($urandom_range(1) == 1);
    foreach (text[i]) begin
      if ($urandom_range(19) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      send_word(text[i], 1'b1, end_on_char && (i == text.size() - 1));
    end
    if (!end_on_char) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic send_lines(input int goal);
    words_sent = 0;
    while (words_sent < goal) send_line($urandom_range(99) < 20);
  endtask

  initial begin
    int src_pcts[4];
    int sink_pcts[4];
    src_pcts  = '{0, 70, 0, 9};
    sink_pcts = '{0, 0, 70, 9};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // blank lines and an idle word
    send_word(8'hA5, 1'b0, 1'b1);
    send_word(CH_SPACE, 1'b1, 1'b0);
    send_word(CH_SPACE, 1'b1, 1'b1);
    send_word(8'hFF, 1'b0, 1'b0);
    // two plain arguments, the second still open at line end
    send_word(8'h61, 1'b1, 1'b0);
    send_word(CH_SPACE, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b1);
    // empty quoted argument
    send_word(CH_DQUOTE, 1'b1, 1'b0);
    send_word(CH_DQUOTE, 1'b1, 1'b1);
    // single quotes holding a space, the other quote and extreme bytes
    send_word(CH_SQUOTE, 1'b1, 1'b0);
    send_word(CH_SPACE, 1'b1, 1'b0);
    send_word(CH_DQUOTE, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(CH_SQUOTE, 1'b1, 1'b1);
    // unbalanced quotes, with and without an open argument
    send_word(CH_DQUOTE, 1'b1, 1'b0);
    send_word(8'h78, 1'b1, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
    send_word(CH_SQUOTE, 1'b1, 1'b1);
    // empty quote closed by a space, then a top-bit byte
    send_word(CH_SQUOTE, 1'b1, 1'b0);
    send_word(CH_SQUOTE, 1'b1, 1'b0);
    send_word(CH_SPACE, 1'b1, 1'b0);
    send_word(8'h80, 1'b1, 1'b1);

    for (int p = 0; p < 4; p++) begin
      idle_pct = src_pcts[p];
      stall_pct <= sink_pcts[p];
      if (p == 0) begin
        // long receiver hold-off while words keep coming, so the input backs up
        fork
          begin
            hold_off <= 1'b1;
            repeat (150) @(posedge clk);
            hold_off <= 1'b0;
          end
          send_lines(34);
        join
      end else begin
        send_lines(34);
      end
    end
    s_axis_tvalid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
